>>> hw/rtl/bba_pkg.sv
// Shared types, codes and constants for the bitmap block allocator.
package bba_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int FRAG_SCALE = 100;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [12:0] TOTAL_BLOCKS_RST = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 1'b1;

  localparam logic [3:0] MODE_ALLOC = 4'd0;
  localparam logic [3:0] MODE_ALLOC_AT = 4'd1;
  localparam logic [3:0] MODE_FREE = 4'd2;
  localparam logic [3:0] MODE_TEST = 4'd3;
  localparam logic [3:0] MODE_CONTIG = 4'd4;
  localparam logic [3:0] MODE_FORMAT = 4'd5;
  localparam logic [3:0] MODE_LARGEST = 4'd6;
  localparam logic [3:0] MODE_FRAG = 4'd7;
  localparam logic [3:0] MODE_CLEAN = 4'd8;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_INVAL = 2'd1;
  localparam logic [1:0] STAT_EXIST = 2'd2;
  localparam logic [1:0] STAT_NOSPACE = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [11:0] block_number;
    logic [12:0] request_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] result_block;
    logic [12:0] run_length;
    logic        is_allocated;
    logic [6:0]  fragment_percent;
    logic [12:0] used_count;
    logic [12:0] search_hint;
    logic        dirty;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_LD,
    ST_DIV,
    ST_FRD,
    ST_FLD,
    ST_FWR,
    ST_FALL,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/bba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
interface bba_req_if;
  logic          valid;
  logic          ready;
  bba_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bba_rsp_if;
  logic          valid;
  logic          ready;
  bba_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/bitmap_block_allocator_unit.sv
// Top level of the next-fit bitmap block allocator.
// Scans walk the bitmap one block per cycle while its word is buffered, pausing to fetch each new
// word through ST_RD and ST_LD; a contiguous fill reads, loads and writes each word it covers,
// format writes every word of the bitmap, and the fragmentation divide forms the percentage bit
// by bit in ST_DIV.
// Throughput: one item at a time; the next is taken once the result is queued.
// Reset: a clearing pass writes zero to every bitmap word; no item is taken meanwhile.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bba_req_if.sink                          req,
  bba_rsp_if.source                        rsp,
  input  logic                             cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int XW = (CW > 13) ? CW : 13;
  localparam int W = (MAX_BLOCKS >= 32) ? 32 : ((MAX_BLOCKS >= 16) ? 16 : 8);
  localparam int S = $clog2(W);
  localparam int DEPTH = (MAX_BLOCKS + W - 1) / W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = XW + 7;
  localparam int IW = AW + S;
  localparam int MW = ((IW > XW) ? IW : XW) + 1;
  localparam logic [XW-1:0] MAXV = XW'(MAX_BLOCKS);
  localparam logic [AW-1:0] LAST_WORD = AW'(DEPTH - 1);

  bba_pkg::state_t state, state_next;

  logic [12:0]    blk_limit;
  logic [11:0]    data_start;
  logic [XW-1:0]  used;
  logic [XW-1:0]  hint;
  logic           dirty;
  logic           clearing;

  logic [3:0]     mode_r;
  logic [XW-1:0]  blk_r;
  logic [XW-1:0]  req_r;
  logic [XW-1:0]  b;
  logic [XW-1:0]  scan_end;
  logic           phase;
  logic [XW-1:0]  found;
  logic [XW-1:0]  start;
  logic [XW-1:0]  best;
  logic [XW-1:0]  best_start;
  logic [XW-1:0]  frags;
  logic           in_free;
  logic [W-1:0]   wbuf;
  logic [AW-1:0]  waddr;
  logic           wvalid;
  logic [AW-1:0]  fw;
  logic [XW-1:0]  fill_lo;
  logic [XW-1:0]  fill_hi;
  logic           fill_set;
  logic [NW-1:0]  div_rem;
  logic [2:0]     div_i;

  logic [1:0]     res_status;
  logic [XW-1:0]  res_block;
  logic [XW-1:0]  res_len;
  logic           res_isalloc;
  logic [6:0]     res_frag;
  logic           out_valid;
  bba_pkg::rsp_t  out_data;

  logic [XW-1:0]  tot;
  logic [XW-1:0]  first_x;
  logic [XW-1:0]  in_blk;
  logic [XW-1:0]  in_req;
  logic [XW-1:0]  avail;
  logic [AW-1:0]  b_word;
  logic [S-1:0]   b_bit;
  logic           cur_bit;
  logic           word_hit;
  logic           scan_stop;
  logic           accept;
  logic [AW-1:0]  fill_last;
  logic [W-1:0]   mask;
  logic [NW-1:0]  frag_num;
  logic [NW-1:0]  used_x100;
  logic [NW-1:0]  div_sub;

  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [W-1:0]   ram_wdata;
  logic [W-1:0]   ram_rdata;

  assign tot = (XW'(blk_limit) > MAXV) ? MAXV : XW'(blk_limit);
  assign first_x = XW'(data_start);
  assign in_blk = XW'(req.data.block_number);
  assign in_req = XW'(req.data.request_count);
  assign avail = (tot > used) ? (tot - used) : '0;
  assign b_word = AW'(b >> S);
  assign b_bit = b[S-1:0];
  assign cur_bit = wbuf[b_bit];
  assign word_hit = wvalid && (waddr == b_word);
  assign scan_stop = (b >= scan_end) || ((mode_r == bba_pkg::MODE_CONTIG) && (found == req_r));
  assign accept = req.valid && req.ready;
  assign fill_last = AW'((fill_hi - XW'(1)) >> S);
  assign frag_num = NW'(frags) * NW'(bba_pkg::FRAG_SCALE);
  assign used_x100 = NW'(used) * NW'(bba_pkg::FRAG_SCALE);
  assign div_sub = NW'(used) << div_i;

  always_comb begin : mask_gen
    logic [IW-1:0] lane_idx;
    for (int j = 0; j < W; j++) begin
      lane_idx = {fw, S'(j)};
      mask[j] = (MW'(lane_idx) >= MW'(fill_lo)) && (MW'(lane_idx) < MW'(fill_hi));
    end
  end

  bba_ram #(
    .WIDTH(W),
    .DEPTH(DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fw),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req.data.mode) inside
            bba_pkg::MODE_ALLOC:
              state_next = (used >= tot) ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
            bba_pkg::MODE_ALLOC_AT, bba_pkg::MODE_TEST:
              state_next = (in_blk >= tot) ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
            bba_pkg::MODE_FREE:
              state_next = (in_blk >= tot || in_blk < first_x) ? bba_pkg::ST_DONE
                                                               : bba_pkg::ST_SCAN;
            bba_pkg::MODE_CONTIG:
              state_next = (in_req == '0 || avail == '0) ? bba_pkg::ST_DONE
                                                         : bba_pkg::ST_SCAN;
            bba_pkg::MODE_FORMAT:
              state_next = (in_req > tot) ? bba_pkg::ST_DONE : bba_pkg::ST_FALL;
            bba_pkg::MODE_LARGEST:
              state_next = bba_pkg::ST_SCAN;
            bba_pkg::MODE_FRAG:
              state_next = (used == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
            default:
              state_next = bba_pkg::ST_DONE;
          endcase
        end
      end
      bba_pkg::ST_SCAN: begin
        if (scan_stop) begin
          case (mode_r)
            bba_pkg::MODE_ALLOC:
              state_next = phase ? bba_pkg::ST_DONE : bba_pkg::ST_SCAN;
            bba_pkg::MODE_CONTIG:
              state_next = (found == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_FRD;
            bba_pkg::MODE_FRAG:
              state_next = (frag_num >= used_x100) ? bba_pkg::ST_DONE : bba_pkg::ST_DIV;
            default:
              state_next = bba_pkg::ST_DONE;
          endcase
        end else if (!word_hit) begin
          state_next = bba_pkg::ST_RD;
        end else begin
          case (mode_r)
            bba_pkg::MODE_ALLOC:
              state_next = cur_bit ? bba_pkg::ST_SCAN : bba_pkg::ST_FWR;
            bba_pkg::MODE_ALLOC_AT:
              state_next = cur_bit ? bba_pkg::ST_DONE : bba_pkg::ST_FWR;
            bba_pkg::MODE_FREE:
              state_next = cur_bit ? bba_pkg::ST_FWR : bba_pkg::ST_DONE;
            bba_pkg::MODE_TEST:
              state_next = bba_pkg::ST_DONE;
            default:
              state_next = bba_pkg::ST_SCAN;
          endcase
        end
      end
      bba_pkg::ST_RD:   state_next = bba_pkg::ST_LD;
      bba_pkg::ST_LD:   state_next = bba_pkg::ST_SCAN;
      bba_pkg::ST_DIV:  state_next = (div_i == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_DIV;
      bba_pkg::ST_FRD:  state_next = bba_pkg::ST_FLD;
      bba_pkg::ST_FLD:  state_next = bba_pkg::ST_FWR;
      bba_pkg::ST_FWR:  state_next = (fw == fill_last) ? bba_pkg::ST_DONE : bba_pkg::ST_FRD;
      bba_pkg::ST_FALL: state_next = (fw == LAST_WORD) ? bba_pkg::ST_DONE : bba_pkg::ST_FALL;
      bba_pkg::ST_DONE: begin
        if (clearing || !out_valid || rsp.ready) begin
          state_next = bba_pkg::ST_IDLE;
        end
      end
      default: state_next = bba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == bba_pkg::ST_IDLE);
    ram_raddr = (state == bba_pkg::ST_RD) ? b_word : fw;
    ram_we = (state == bba_pkg::ST_FWR) || (state == bba_pkg::ST_FALL);
    if (state == bba_pkg::ST_FALL) begin
      ram_wdata = mask;
    end else if (fill_set) begin
      ram_wdata = wbuf | mask;
    end else begin
      ram_wdata = wbuf & ~mask;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_FALL;
      clearing <= 1'b1;
      fw <= '0;
      fill_lo <= '0;
      fill_hi <= '0;
      fill_set <= 1'b0;
      used <= '0;
      hint <= '0;
      dirty <= 1'b0;
      blk_limit <= bba_pkg::TOTAL_BLOCKS_RST;
      data_start <= '0;
      out_valid <= 1'b0;
      wvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        bba_pkg::ST_IDLE: begin
          if (accept) begin
            mode_r <= req.data.mode;
            blk_r <= in_blk;
            wvalid <= 1'b0;
            phase <= 1'b0;
            found <= '0;
            start <= '0;
            best <= '0;
            best_start <= '0;
            frags <= '0;
            in_free <= 1'b0;
            res_status <= bba_pkg::STAT_OK;
            res_block <= '0;
            res_len <= '0;
            res_isalloc <= 1'b0;
            res_frag <= '0;
            b <= first_x;
            scan_end <= tot;
            unique case (req.data.mode) inside
              bba_pkg::MODE_ALLOC: begin
                b <= hint;
                if (used >= tot) begin
                  res_status <= bba_pkg::STAT_NOSPACE;
                end
              end
              bba_pkg::MODE_ALLOC_AT, bba_pkg::MODE_TEST: begin
                b <= in_blk;
                scan_end <= in_blk + XW'(1);
                if (in_blk >= tot && req.data.mode == bba_pkg::MODE_ALLOC_AT) begin
                  res_status <= bba_pkg::STAT_INVAL;
                end
              end
              bba_pkg::MODE_FREE: begin
                b <= in_blk;
                scan_end <= in_blk + XW'(1);
                if (in_blk >= tot || in_blk < first_x) begin
                  res_status <= bba_pkg::STAT_INVAL;
                end
              end
              bba_pkg::MODE_CONTIG: begin
                req_r <= (in_req > avail) ? avail : in_req;
                if (in_req == '0) begin
                  res_status <= bba_pkg::STAT_INVAL;
                end else if (avail == '0) begin
                  res_status <= bba_pkg::STAT_NOSPACE;
                end
              end
              bba_pkg::MODE_FORMAT: begin
                if (in_req > tot) begin
                  res_status <= bba_pkg::STAT_INVAL;
                end else begin
                  used <= in_req;
                  hint <= in_req;
                  dirty <= 1'b1;
                  fill_lo <= '0;
                  fill_hi <= in_req;
                  fw <= '0;
                end
              end
              bba_pkg::MODE_LARGEST, bba_pkg::MODE_FRAG: begin
              end
              bba_pkg::MODE_CLEAN: begin
                dirty <= 1'b0;
              end
              default: begin
                res_status <= bba_pkg::STAT_INVAL;
              end
            endcase
          end
        end
        bba_pkg::ST_SCAN: begin
          if (scan_stop) begin
            case (mode_r)
              bba_pkg::MODE_ALLOC: begin
                if (phase) begin
                  res_status <= bba_pkg::STAT_NOSPACE;
                end else begin
                  phase <= 1'b1;
                  b <= first_x;
                  scan_end <= (hint < tot) ? hint : tot;
                end
              end
              bba_pkg::MODE_CONTIG: begin
                if (found == '0) begin
                  res_status <= bba_pkg::STAT_NOSPACE;
                end else begin
                  fill_lo <= start;
                  fill_hi <= start + found;
                  fill_set <= 1'b1;
                  fw <= AW'(start >> S);
                  used <= used + found;
                  hint <= start + found;
                  dirty <= 1'b1;
                  res_block <= start;
                  res_len <= found;
                end
              end
              bba_pkg::MODE_LARGEST: begin
                if (found > best) begin
                  res_block <= start;
                  res_len <= found;
                end else begin
                  res_block <= best_start;
                  res_len <= best;
                end
              end
              bba_pkg::MODE_FRAG: begin
                if (frag_num >= used_x100) begin
                  res_frag <= 7'(bba_pkg::FRAG_SCALE);
                end else begin
                  div_rem <= frag_num;
                  div_i <= 3'd6;
                end
              end
              default: begin
              end
            endcase
          end else if (word_hit) begin
            b <= b + XW'(1);
            fill_lo <= b;
            fill_hi <= b + XW'(1);
            fw <= b_word;
            case (mode_r)
              bba_pkg::MODE_ALLOC: begin
                if (!cur_bit) begin
                  fill_set <= 1'b1;
                  used <= used + XW'(1);
                  hint <= b + XW'(1);
                  dirty <= 1'b1;
                  res_block <= b;
                end
              end
              bba_pkg::MODE_ALLOC_AT: begin
                if (cur_bit) begin
                  res_status <= bba_pkg::STAT_EXIST;
                end else begin
                  fill_set <= 1'b1;
                  used <= used + XW'(1);
                  dirty <= 1'b1;
                  if (blk_r < hint) begin
                    hint <= blk_r + XW'(1);
                  end
                end
              end
              bba_pkg::MODE_FREE: begin
                if (!cur_bit) begin
                  res_status <= bba_pkg::STAT_INVAL;
                end else begin
                  fill_set <= 1'b0;
                  if (used != '0) begin
                    used <= used - XW'(1);
                  end
                  dirty <= 1'b1;
                  if (blk_r < hint) begin
                    hint <= blk_r;
                  end
                end
              end
              bba_pkg::MODE_TEST: begin
                res_isalloc <= cur_bit;
              end
              bba_pkg::MODE_CONTIG: begin
                if (!cur_bit) begin
                  if (found == '0) begin
                    start <= b;
                  end
                  found <= found + XW'(1);
                end else begin
                  found <= '0;
                end
              end
              bba_pkg::MODE_LARGEST: begin
                if (!cur_bit) begin
                  if (found == '0) begin
                    start <= b;
                  end
                  found <= found + XW'(1);
                end else begin
                  if (found > best) begin
                    best <= found;
                    best_start <= start;
                  end
                  found <= '0;
                end
              end
              bba_pkg::MODE_FRAG: begin
                if (!cur_bit && !in_free) begin
                  in_free <= 1'b1;
                end else if (cur_bit && in_free) begin
                  frags <= frags + XW'(1);
                  in_free <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        bba_pkg::ST_LD: begin
          wbuf <= ram_rdata;
          waddr <= b_word;
          wvalid <= 1'b1;
        end
        bba_pkg::ST_DIV: begin
          if (div_rem >= div_sub) begin
            div_rem <= div_rem - div_sub;
            res_frag[div_i] <= 1'b1;
          end
          div_i <= div_i - 3'd1;
        end
        bba_pkg::ST_FLD: begin
          wbuf <= ram_rdata;
        end
        bba_pkg::ST_FWR: begin
          wvalid <= 1'b0;
          if (fw != fill_last) begin
            fw <= fw + AW'(1);
          end
        end
        bba_pkg::ST_FALL: begin
          if (fw != LAST_WORD) begin
            fw <= fw + AW'(1);
          end
        end
        bba_pkg::ST_DONE: begin
          if (clearing) begin
            clearing <= 1'b0;
          end else if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_data.status <= res_status;
            out_data.result_block <= res_block[11:0];
            out_data.run_length <= res_len[12:0];
            out_data.is_allocated <= res_isalloc;
            out_data.fragment_percent <= res_frag;
            out_data.used_count <= used[12:0];
            out_data.search_hint <= hint[12:0];
            out_data.dirty <= dirty;
          end
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        if (cfg_index == bba_pkg::CFG_TOTAL_BLOCKS) begin
          blk_limit <= cfg_data;
        end else if (cfg_index == bba_pkg::CFG_FIRST_DATA_BLOCK) begin
          data_start <= cfg_data[11:0];
          hint <= XW'(cfg_data[11:0]);
        end
      end
    end
  end

endmodule

>>> hw/rtl/bba_ram.sv
// Generic single-port-write, registered-read RAM.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> dv/tb_bitmap_block_allocator_unit.sv
// Self-checking testbench for the bitmap block allocator: random handshakes, bit-exact prediction.
`timescale 1ns / 1ps
module tb_bitmap_block_allocator_unit;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data;

  bba_req_if req_ch();
  bba_rsp_if rsp_ch();

  bitmap_block_allocator_unit i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // allocator image
  bit        usage_map [bba_pkg::MAX_BLOCKS_DEF];
  int        used_ref;
  int        fit_hint;
  bit        dirty_flag;
  int        total_cfg;
  int        first_cfg;

  bba_pkg::req_t pending_items[$];
  bba_pkg::rsp_t expected_rsps[$];
  int        n_sent;
  int        n_taken;
  int        req_gap;
  int        rsp_gap;
  int        errors;
  int        cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit is_used(input int b);
    return b < bba_pkg::MAX_BLOCKS_DEF && b >= 0 && usage_map[b];
  endfunction

  function automatic bba_pkg::rsp_t allocate_predict(input bba_pkg::req_t it);
    bba_pkg::rsp_t r;
    int tot, b, found, start, avail, want, best, best_start, cur, cur_start, frags;
    int wrap_end, blk, pick;
    bit hit, in_free;
    tot = total_cfg > bba_pkg::MAX_BLOCKS_DEF ? bba_pkg::MAX_BLOCKS_DEF : total_cfg;
    blk = it.block_number;
    r = '0;
    r.status = bba_pkg::STAT_OK;
    case (it.mode)
      bba_pkg::MODE_ALLOC: begin
        r.status = bba_pkg::STAT_NOSPACE;
        if (used_ref < tot) begin
          hit = 1'b0;
          pick = 0;
          wrap_end = fit_hint < tot ? fit_hint : tot;
          for (b = fit_hint; b < tot && !hit; b++)
            if (!is_used(b)) begin pick = b; hit = 1'b1; end
          for (b = first_cfg; b < wrap_end && !hit; b++)
            if (!is_used(b)) begin pick = b; hit = 1'b1; end
          if (hit) begin
            usage_map[pick] = 1'b1;
            used_ref++;
            dirty_flag = 1'b1;
            fit_hint = pick + 1;
            r.result_block = 12'(pick);
            r.status = bba_pkg::STAT_OK;
          end
        end
      end
      bba_pkg::MODE_ALLOC_AT: begin
        if (blk >= tot) r.status = bba_pkg::STAT_INVAL;
        else if (is_used(blk)) r.status = bba_pkg::STAT_EXIST;
        else begin
          usage_map[blk] = 1'b1;
          used_ref++;
          dirty_flag = 1'b1;
          if (blk < fit_hint) fit_hint = blk + 1;
        end
      end
      bba_pkg::MODE_FREE: begin
        if (blk >= tot || blk < first_cfg || !is_used(blk)) r.status = bba_pkg::STAT_INVAL;
        else begin
          usage_map[blk] = 1'b0;
          if (used_ref > 0) used_ref--;
          dirty_flag = 1'b1;
          if (blk < fit_hint) fit_hint = blk;
        end
      end
      bba_pkg::MODE_TEST: r.is_allocated = blk < tot && is_used(blk);
      bba_pkg::MODE_CONTIG: begin
        avail = tot > used_ref ? tot - used_ref : 0;
        want = it.request_count;
        if (want == 0) r.status = bba_pkg::STAT_INVAL;
        else if (avail == 0) r.status = bba_pkg::STAT_NOSPACE;
        else begin
          if (want > avail) want = avail;
          found = 0;
          start = 0;
          for (b = first_cfg; b < tot && found < want; b++) begin
            if (!is_used(b)) begin
              if (found == 0) start = b;
              found++;
            end else found = 0;
          end
          if (found == 0) r.status = bba_pkg::STAT_NOSPACE;
          else begin
            for (b = start; b < start + found; b++)
              if (b < bba_pkg::MAX_BLOCKS_DEF) usage_map[b] = 1'b1;
            used_ref += found;
            fit_hint = (start + found) & 13'h1FFF;
            dirty_flag = 1'b1;
            r.result_block = 12'(start);
            r.run_length = 13'(found);
          end
        end
      end
      bba_pkg::MODE_FORMAT: begin
        if (it.request_count > tot) r.status = bba_pkg::STAT_INVAL;
        else begin
          for (b = 0; b < bba_pkg::MAX_BLOCKS_DEF; b++) usage_map[b] = b < it.request_count;
          used_ref = it.request_count;
          fit_hint = it.request_count;
          dirty_flag = 1'b1;
        end
      end
      bba_pkg::MODE_LARGEST: begin
        best = 0; best_start = 0; cur = 0; cur_start = 0;
        for (b = first_cfg; b < tot; b++) begin
          if (!is_used(b)) begin
            if (cur == 0) cur_start = b;
            cur++;
          end else begin
            if (cur > best) begin best = cur; best_start = cur_start; end
            cur = 0;
          end
        end
        if (cur > best) begin best = cur; best_start = cur_start; end
        r.result_block = 12'(best_start);
        r.run_length = 13'(best);
      end
      bba_pkg::MODE_FRAG: begin
        if (used_ref != 0) begin
          frags = 0;
          in_free = 1'b0;
          for (b = first_cfg; b < tot; b++) begin
            if (!is_used(b) && !in_free) in_free = 1'b1;
            else if (is_used(b) && in_free) begin frags++; in_free = 1'b0; end
          end
          frags = frags * bba_pkg::FRAG_SCALE / used_ref;
          r.fragment_percent = 7'(frags > bba_pkg::FRAG_SCALE ? bba_pkg::FRAG_SCALE : frags);
        end
      end
      bba_pkg::MODE_CLEAN: dirty_flag = 1'b0;
      default: r.status = bba_pkg::STAT_INVAL;
    endcase
    r.used_count = 13'(used_ref);
    r.search_hint = 13'(fit_hint);
    r.dirty = dirty_flag;
    return r;
  endfunction

  function automatic bba_pkg::req_t mk(input logic [3:0] m, input int blk, input int cnt);
    bba_pkg::req_t it;
    it.mode = m;
    it.block_number = 12'(blk);
    it.request_count = 13'(cnt);
    return it;
  endfunction

  function automatic bba_pkg::req_t random_item(input int tot);
    bba_pkg::req_t it;
    int r, lim;
    lim = tot > bba_pkg::MAX_BLOCKS_DEF ? bba_pkg::MAX_BLOCKS_DEF : tot;
    it = bba_pkg::req_t'($urandom);
    r = $urandom_range(99);
    if (r < 25) it.mode = bba_pkg::MODE_ALLOC;
    else if (r < 38) it.mode = bba_pkg::MODE_ALLOC_AT;
    else if (r < 56) it.mode = bba_pkg::MODE_FREE;
    else if (r < 66) it.mode = bba_pkg::MODE_TEST;
    else if (r < 77) it.mode = bba_pkg::MODE_CONTIG;
    else if (r < 81) it.mode = bba_pkg::MODE_FORMAT;
    else if (r < 86) it.mode = bba_pkg::MODE_LARGEST;
    else if (r < 91) it.mode = bba_pkg::MODE_FRAG;
    else if (r < 95) it.mode = bba_pkg::MODE_CLEAN;
    else it.mode = 4'($urandom_range(15));
    if ($urandom_range(9) != 0) it.block_number = 12'($urandom_range(lim + 1));
    r = $urandom_range(9);
    if (r < 6) it.request_count = 13'($urandom_range(8));
    else if (r < 9) it.request_count = 13'($urandom_range(lim + 1));
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || n_sent != n_taken || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bba_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bba_pkg::CFG_DATA_W'(val);
    if (idx == bba_pkg::CFG_TOTAL_BLOCKS) total_cfg = val & 13'h1FFF;
    else begin
      first_cfg = val & 12'hFFF;
      fit_hint = first_cfg;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    int g;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_gap = 0;
    end else if (!(req_ch.valid && n_sent != n_taken)) begin
      g = req_gap;
      if (g > 0) begin
        req_gap = g - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        req_ch.data <= pending_items.pop_front();
        req_ch.valid <= 1'b1;
        n_sent++;
        req_gap = pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) rsp_ch.ready <= 1'b0;
    else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      rsp_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    bba_pkg::rsp_t want;
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsps.push_back(allocate_predict(req_ch.data));
      n_taken++;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) report("response with no item outstanding");
      else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.data.status !== want.status)
          report($sformatf("status %0d want %0d", rsp_ch.data.status, want.status));
        if (rsp_ch.data.result_block !== want.result_block)
          report($sformatf("result_block %0d want %0d", rsp_ch.data.result_block,
                           want.result_block));
        if (rsp_ch.data.run_length !== want.run_length)
          report($sformatf("run_length %0d want %0d", rsp_ch.data.run_length,
                           want.run_length));
        if (rsp_ch.data.is_allocated !== want.is_allocated)
          report($sformatf("is_allocated %0d want %0d", rsp_ch.data.is_allocated,
                           want.is_allocated));
        if (rsp_ch.data.fragment_percent !== want.fragment_percent)
          report($sformatf("fragment_percent %0d want %0d", rsp_ch.data.fragment_percent,
                           want.fragment_percent));
        if (rsp_ch.data.used_count !== want.used_count)
          report($sformatf("used_count %0d want %0d", rsp_ch.data.used_count,
                           want.used_count));
        if (rsp_ch.data.search_hint !== want.search_hint)
          report($sformatf("search_hint %0d want %0d", rsp_ch.data.search_hint,
                           want.search_hint));
        if (rsp_ch.data.dirty !== want.dirty)
          report($sformatf("dirty %0d want %0d", rsp_ch.data.dirty, want.dirty));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 6000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int phase_total[10] = '{4096, 8191, 1, 0, 64, 200, 37, 128, 256, 4096};
    int phase_first[10] = '{0, 5, 0, 0, 0, 7, 3, 127, 16, 4095};
    int phase_items[10] = '{0, 40, 60, 30, 250, 250, 250, 150, 200, 30};
    int p, k;
    clk = 1'b0;
    errors = 0;
    cycles = 0;
    n_sent = 0;
    n_taken = 0;
    rsp_gap = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    for (k = 0; k < bba_pkg::MAX_BLOCKS_DEF; k++) usage_map[k] = 1'b0;
    used_ref = 0;
    fit_hint = 0;
    dirty_flag = 1'b0;
    total_cfg = bba_pkg::TOTAL_BLOCKS_RST;
    first_cfg = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_items.push_back(mk(bba_pkg::MODE_ALLOC, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_ALLOC, 4095, 8191));
    pending_items.push_back(mk(bba_pkg::MODE_ALLOC_AT, 4095, 0));
    pending_items.push_back(mk(bba_pkg::MODE_ALLOC_AT, 4095, 0));
    pending_items.push_back(mk(bba_pkg::MODE_TEST, 4095, 0));
    pending_items.push_back(mk(bba_pkg::MODE_TEST, 2, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FREE, 4095, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FREE, 4095, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FREE, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_CONTIG, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_CONTIG, 0, 5));
    pending_items.push_back(mk(bba_pkg::MODE_LARGEST, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FRAG, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_CLEAN, 0, 0));
    pending_items.push_back(mk(4'd9, 0, 0));
    pending_items.push_back(mk(4'd15, 4095, 8191));
    pending_items.push_back(mk(bba_pkg::MODE_FORMAT, 0, 8191));
    pending_items.push_back(mk(bba_pkg::MODE_FORMAT, 0, 4096));
    pending_items.push_back(mk(bba_pkg::MODE_ALLOC, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_CONTIG, 0, 1));
    pending_items.push_back(mk(bba_pkg::MODE_FRAG, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FORMAT, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_FRAG, 0, 0));
    pending_items.push_back(mk(bba_pkg::MODE_CONTIG, 0, 8191));
    pending_items.push_back(mk(bba_pkg::MODE_FREE, 100, 0));

    for (p = 1; p < 10; p++) begin
      wait_idle();
      write_reg(bba_pkg::CFG_TOTAL_BLOCKS, phase_total[p]);
      write_reg(bba_pkg::CFG_FIRST_DATA_BLOCK, phase_first[p]);
      for (k = 0; k < phase_items[p]; k++) pending_items.push_back(random_item(phase_total[p]));
    end
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
